@@ hw/rtl/nsbh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbh_pkg: shared types and constants
// Formats and the front-to-back queue entry for the segment/box hit unit.
// ----------------------------------------------------------------------------
package nsbh_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned TW     = 16;
  localparam int unsigned NumW   = 43;   // (plane - start) * 65536, signed
  localparam int unsigned QuotW  = 43;   // slab parameter, signed
  localparam logic signed [25:0] HalfQ12 = 26'sd2048;
  localparam logic signed [QuotW-1:0] OneQ16 = 43'sd65536;
  localparam logic signed [25:0] C24Max = 26'sd8388607;
  localparam logic signed [25:0] C24Min = -26'sd8388608;

  localparam logic ActWrite = 1'b0;
  localparam logic ActTrace = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [7:0]               entry_index;
    logic                     entry_is_block;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ez;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] sz;
    logic signed [CoordW-1:0] dx_end;
    logic signed [CoordW-1:0] dy_end;
    logic signed [CoordW-1:0] dz_end;
  } cmd_t;

endpackage

@@ hw/rtl/nsbh_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbh_fifo: two-entry command queue
// Decouples the input front from the scanning back end.
// ----------------------------------------------------------------------------
module nsbh_fifo
  import nsbh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ hw/rtl/nsbh_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbh_div: iterative signed floor divider
// One quotient bit per cycle, restoring, on magnitudes; floor fix at the end.
// ----------------------------------------------------------------------------
module nsbh_div
  import nsbh_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NumW-1:0]  num_i,
  input  logic signed [25:0]      den_i,
  output logic                    done_o,
  output logic signed [QuotW-1:0] quot_o
);
  logic [NumW-1:0] q_q;
  logic [26:0]     rem_q;
  logic [25:0]     dm_q;
  logic            neg_q, busy_q;
  logic [5:0]      cnt_q;
  logic [26:0]     trial;
  logic [NumW-1:0] nm;

  assign nm    = num_i[NumW-1] ? NumW'(-num_i) : num_i;
  assign trial = {rem_q[25:0], q_q[NumW-1]} - {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= nm;
      rem_q <= '0;
      dm_q  <= den_i[25] ? 26'(-den_i) : den_i;
      neg_q <= num_i[NumW-1] ^ den_i[25];
    end else if (busy_q) begin
      if (!trial[26]) begin
        rem_q <= trial;
        q_q   <= {q_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[25:0], q_q[NumW-1]};
        q_q   <= {q_q[NumW-2:0], 1'b0};
      end
    end
  end

  // Floor correction: negative quotient with non-zero remainder steps down.
  always_comb begin
    if (neg_q) begin
      quot_o = (rem_q != '0) ? -$signed(q_q) - 43'sd1 : -$signed(q_q);
    end else begin
      quot_o = $signed(q_q);
    end
  end
endmodule

@@ hw/rtl/nsbh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsbh_back: table store and trace engine
// Writes entries; scans entries through the slab clip and forms the result.
// ----------------------------------------------------------------------------
module nsbh_back
  import nsbh_pkg::*;
#(
  parameter int unsigned MaxEntries = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [8:0]               entity_count_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  cmd_t                     cmd_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     hit_o,
  output logic [TW-1:0]            hit_t_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o,
  output logic signed [CoordW-1:0] hit_z_o
);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SRead  = 10'b0000000010,
    SLoad  = 10'b0000000100,
    SDivA  = 10'b0000001000,
    SDivB  = 10'b0000010000,
    SSlab  = 10'b0000100000,
    SNext  = 10'b0001000000,
    SMul   = 10'b0010000000,
    SPoint = 10'b0100000000,
    SOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] mx [MaxEntries];
  logic signed [CoordW-1:0] my [MaxEntries];
  logic signed [CoordW-1:0] mz [MaxEntries];
  logic                     mb [MaxEntries];
  logic [MaxEntries-1:0]    valid_q;

  logic signed [CoordW-1:0] rx_q, ry_q, rz_q;
  logic                     rb_q, rv_q;
  cmd_t                     cur_q;
  logic [CntW-1:0]          idx_q, n_q;
  logic [1:0]               ax_q;
  logic signed [QuotW-1:0]  tl_q, th_q, a_q, best_q;
  logic                     found_q, ok_q;
  logic signed [25:0]       s_ax, d_ax, c_ax, lo, hi;
  logic signed [NumW-1:0]   num;
  logic                     div_start, div_done;
  logic signed [QuotW-1:0]  quot, lo_t, hi_t;
  logic signed [41:0]       prod_q;
  logic [1:0]               pax_q;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic                     res_v_q;
  logic [CntW-1:0]          ncount;
  logic signed [25:0]       pt;

  assign ncount = (32'(entity_count_i) > MaxEntries) ? CntW'(MaxEntries)
                                                    : CntW'(entity_count_i);
  assign cmd_ready_o = (state_q == SIdle) && !res_v_q;

  always_comb begin
    unique case (ax_q)
      2'd0:    begin s_ax = 26'(cur_q.sx); c_ax = 26'(rx_q);
                 d_ax = 26'(cur_q.dx_end) - 26'(cur_q.sx); end
      2'd1:    begin s_ax = 26'(cur_q.sy); c_ax = 26'(ry_q);
                 d_ax = 26'(cur_q.dy_end) - 26'(cur_q.sy); end
      default: begin s_ax = 26'(cur_q.sz); c_ax = 26'(rz_q);
                 d_ax = 26'(cur_q.dz_end) - 26'(cur_q.sz); end
    endcase
  end
  assign lo  = c_ax - HalfQ12;
  assign hi  = c_ax + HalfQ12;
  assign num = (state_q == SDivA) ? NumW'(lo - s_ax) <<< 16 : NumW'(hi - s_ax) <<< 16;
  assign div_start = ((state_q == SLoad) && d_ax != '0 && ok_q)
                  || ((state_q == SDivA) && div_done);

  nsbh_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (num),
    .den_i   (d_ax),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign lo_t = (a_q < quot) ? a_q : quot;
  assign hi_t = (a_q < quot) ? quot : a_q;

  // Hit point for the current axis of the product stage.
  always_comb begin
    logic signed [25:0] sp;
    unique case (pax_q)
      2'd0:    sp = 26'(cur_q.sx);
      2'd1:    sp = 26'(cur_q.sy);
      default: sp = 26'(cur_q.sz);
    endcase
    pt = sp + 26'(prod_q >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && cmd_valid_i && cmd_ready_o && cmd_i.action == ActWrite
        && 32'(cmd_i.entry_index) < MaxEntries) begin
      mx[IdxW'(cmd_i.entry_index)] <= cmd_i.ex;
      my[IdxW'(cmd_i.entry_index)] <= cmd_i.ey;
      mz[IdxW'(cmd_i.entry_index)] <= cmd_i.ez;
      mb[IdxW'(cmd_i.entry_index)] <= cmd_i.entry_is_block;
    end
    rx_q <= mx[idx_q[IdxW-1:0]];
    ry_q <= my[idx_q[IdxW-1:0]];
    rz_q <= mz[idx_q[IdxW-1:0]];
    rb_q <= mb[idx_q[IdxW-1:0]];
    rv_q <= valid_q[idx_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:  if (cmd_valid_i && cmd_ready_o && cmd_i.action == ActTrace) state_d = SNext;
      SNext:  state_d = (idx_q == n_q) ? SMul : SRead;
      SRead:  state_d = SLoad;
      SLoad:  begin
        if (!(rb_q && rv_q) || !ok_q || ax_q == 2'd3) state_d = SSlab;
        else if (d_ax != '0) state_d = SDivA;
      end
      SDivA:  if (div_done) state_d = SDivB;
      SDivB:  if (div_done) state_d = SLoad;
      SSlab:  state_d = SNext;
      SMul:   state_d = SPoint;
      SPoint: state_d = (pax_q == 2'd2) ? SOut : SMul;
      SOut:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_q <= '0;
      res_v_q <= 1'b0;
      idx_q   <= '0;
      n_q     <= '0;
      ax_q    <= '0;
      ok_q    <= 1'b0;
      found_q <= 1'b0;
      pax_q   <= '0;
    end else begin
      state_q <= state_d;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      unique case (state_q)
        SIdle: if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i.action == ActWrite) begin
            if (32'(cmd_i.entry_index) < MaxEntries)
              valid_q[IdxW'(cmd_i.entry_index)] <= 1'b1;
          end else begin
            idx_q   <= '0;
            n_q     <= ncount;
            found_q <= 1'b0;
          end
        end
        SNext: if (idx_q != n_q) begin
          ax_q <= 2'd0;
          ok_q <= 1'b1;
        end
        SLoad: if (rb_q && rv_q && ok_q && ax_q != 2'd3 && d_ax == '0) begin
          ok_q <= !(s_ax < lo || s_ax > hi);
          ax_q <= ax_q + 2'd1;
        end
        SDivB: if (div_done) begin
          ax_q <= ax_q + 2'd1;
          if (hi_t < tl_q || lo_t > th_q) ok_q <= 1'b0;
          else ok_q <= ((lo_t > tl_q) ? lo_t : tl_q) <= ((hi_t < th_q) ? hi_t : th_q);
        end
        SSlab: begin
          idx_q <= idx_q + CntW'(1);
          if (rb_q && rv_q && ok_q && tl_q < best_q) found_q <= 1'b1;
        end
        SMul:   ;
        SPoint: pax_q <= pax_q + 2'd1;
        SOut: begin
          res_v_q <= 1'b1;
          pax_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      // best held while a result waits; set to OneQ16 only when a trace starts
      SIdle: if (cmd_valid_i && cmd_ready_o && cmd_i.action == ActTrace) best_q <= OneQ16;
      SNext: begin tl_q <= '0; th_q <= OneQ16; end
      SDivA: if (div_done) a_q <= quot;
      SDivB: if (div_done) begin
        if (lo_t > tl_q) tl_q <= lo_t;
        if (hi_t < th_q) th_q <= hi_t;
      end
      SSlab: if (rb_q && rv_q && ok_q && tl_q < best_q) best_q <= tl_q;
      SMul: begin
        unique case (pax_q)
          2'd0:    prod_q <= 42'(26'(cur_q.dx_end) - 26'(cur_q.sx)) * 42'(best_q[16:0]);
          2'd1:    prod_q <= 42'(26'(cur_q.dy_end) - 26'(cur_q.sy)) * 42'(best_q[16:0]);
          default: prod_q <= 42'(26'(cur_q.dz_end) - 26'(cur_q.sz)) * 42'(best_q[16:0]);
        endcase
      end
      SPoint: begin
        logic signed [CoordW-1:0] sat;
        sat = (pt > C24Max) ? CoordW'(C24Max) : (pt < C24Min) ? CoordW'(C24Min)
                                                             : CoordW'(pt);
        unique case (pax_q)
          2'd0:    px_q <= sat;
          2'd1:    py_q <= sat;
          default: pz_q <= sat;
        endcase
      end
      default: ;
    endcase
    if (state_q == SIdle && cmd_valid_i && cmd_ready_o) cur_q <= cmd_i;
  end

  assign res_valid_o = res_v_q;
  assign hit_o   = found_q;
  assign hit_t_o = found_q ? best_q[TW-1:0] : '0;
  assign hit_x_o = found_q ? px_q : '0;
  assign hit_y_o = found_q ? py_q : '0;
  assign hit_z_o = found_q ? pz_q : '0;
endmodule

@@ hw/rtl/nearest_segment_box_hit_unit.sv @@
`timescale 1ns / 1ps
// Order: a write is stored as the back end accepts it; a trace passes the queue,
// then SNext, SRead, SLoad, SSlab per entry; a flagged entry adds SLoad per axis
// tested, two serial floor divides per non-parallel axis, then SMul, SPoint, SOut.
// Throughput: one item in the back end at a time; a 2-item queue buffers input.
// Reset: asynchronous active low; entry valid bits clear, so no entry is tested,
// and entity_count returns to 0.
// ----------------------------------------------------------------------------
// nearest_segment_box_hit_unit: segment versus unit-box slab hit test
// APB register, input queue and scanning back end.
// ----------------------------------------------------------------------------
module nearest_segment_box_hit_unit
  import nsbh_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [7:0]               entry_index_i,
  input  logic                     entry_is_block_i,
  input  logic signed [CoordW-1:0] entry_x_i,
  input  logic signed [CoordW-1:0] entry_y_i,
  input  logic signed [CoordW-1:0] entry_z_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] end_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  output logic [TW-1:0]            hit_t_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o,
  output logic signed [CoordW-1:0] hit_z_o
);
  logic [8:0] entity_count_q;
  cmd_t       in_cmd, q_cmd;
  logic       q_valid, q_ready;

  // Single register at address 0; other addresses read as zero.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {23'd0, entity_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entity_count_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      entity_count_q <= pwdata[8:0];
    end
  end

  assign in_cmd = '{action: action_i, entry_index: entry_index_i,
                    entry_is_block: entry_is_block_i, ex: entry_x_i, ey: entry_y_i,
                    ez: entry_z_i, sx: start_x_i, sy: start_y_i, sz: start_z_i,
                    dx_end: end_x_i, dy_end: end_y_i, dz_end: end_z_i};

  // Front: queue parts the input handshake from the scan engine.
  nsbh_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (in_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  nsbh_back #(.MaxEntries(MAX_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .entity_count_i (entity_count_q),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (q_cmd),
    .res_valid_o    (out_valid_o),
    .res_ready_i    (out_ready_i),
    .hit_o, .hit_t_o, .hit_x_o, .hit_y_o, .hit_z_o
  );
endmodule
